[rtl/assert_macros.svh]
// Assertion macros shared by the max pooling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MP_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("max pool assertion failed");

`define MP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("max pool assertion failed");

`define MP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("max pool assertion failed");

`else

`define MP_ASSERT(lbl, clk, rstn, expr)
`define MP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/mp2a_pkg.sv]
package mp2a_pkg;

  localparam int K_MAX_DEF     = 8;
  localparam int W_MAX_DEF     = 256;
  localparam int H_MAX_DEF     = 256;
  localparam int DATA_BITS_DEF = 16;

  localparam int KSIZE_W  = 4;
  localparam int STRIDE_W = 4;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [KSIZE_W-1:0]  KERNEL_RST = 4'd2;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 4'd2;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } scan_state_t;

  // Output coordinates and window origin of a window that closes.
  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] row0;
    logic [COORD_W-1:0] col0;
  } win_t;

endpackage

[rtl/mp2a_ram.sv]
module mp2a_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mp2a_pos.sv]
`include "assert_macros.svh"

module mp2a_pos import mp2a_pkg::*; #(
  parameter int K_MAX = K_MAX_DEF,
  parameter int W_MAX = W_MAX_DEF,
  parameter int H_MAX = H_MAX_DEF,
  localparam int KW = $clog2(K_MAX + 1),
  localparam int SW = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  localparam int CW = $clog2(W_MAX),
  localparam int RW = $clog2(H_MAX),
  localparam int WW = $clog2(W_MAX + 1),
  localparam int HW = $clog2(H_MAX + 1),
  localparam int AW = $clog2(K_MAX * W_MAX)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  logic                step,
  input  logic [KW-1:0]       k_eff,
  input  logic [STRIDE_W-1:0] s_eff,
  input  logic [WW-1:0]       w_eff,
  input  logic [HW-1:0]       h_eff,
  output logic [AW-1:0]       wr_addr,
  output logic                close,
  output logic [SW-1:0]       base_slot,
  output logic [CW-1:0]       base_col,
  output win_t                win
);

  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [STRIDE_W-1:0] rph_r, rph_nxt;
  logic [STRIDE_W-1:0] cph_r, cph_nxt;
  logic [RW-1:0]       orow_r, orow_nxt;
  logic [CW-1:0]       ocol_r, ocol_nxt;

  logic col_last, row_last, col_in, row_in, cph_wrap, rph_wrap, slot_wrap;

  assign col_last  = (WW'(col_r) + 1'b1) == w_eff;
  assign row_last  = (HW'(row_r) + 1'b1) == h_eff;
  // A row or column is inside the window region once a whole kernel fits up to and including it.
  assign col_in    = (WW'(col_r) + 1'b1) >= k_eff;
  assign row_in    = (HW'(row_r) + 1'b1) >= k_eff;
  assign cph_wrap  = (cph_r + 1'b1) == s_eff;
  assign rph_wrap  = (rph_r + 1'b1) == s_eff;
  assign slot_wrap = (KW'(slot_r) + 1'b1) == k_eff;

  assign close     = row_in && col_in && (rph_r == '0) && (cph_r == '0);
  // The oldest row of the window sits in the slot after the current one.
  assign base_slot = slot_wrap ? '0 : slot_r + 1'b1;
  assign base_col  = CW'(col_r + 1'b1 - k_eff);
  assign wr_addr   = AW'(slot_r) * AW'(W_MAX) + AW'(col_r);

  assign win.out_row = COORD_W'(orow_r);
  assign win.out_col = COORD_W'(ocol_r);
  assign win.row0    = COORD_W'(row_r + 1'b1 - k_eff);
  assign win.col0    = COORD_W'(col_r + 1'b1 - k_eff);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    rph_nxt  = rph_r;
    cph_nxt  = cph_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = '0;
      rph_nxt  = '0;
      cph_nxt  = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
    end else if (step) begin
      if (col_last) begin
        col_nxt  = '0;
        cph_nxt  = '0;
        ocol_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
          rph_nxt  = '0;
          orow_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = base_slot;
          if (row_in) begin
            rph_nxt = rph_wrap ? '0 : rph_r + 1'b1;
            if (rph_wrap) begin
              orow_nxt = orow_r + 1'b1;
            end
          end
        end
      end else begin
        col_nxt = col_r + 1'b1;
        if (col_in) begin
          cph_nxt = cph_wrap ? '0 : cph_r + 1'b1;
          if (cph_wrap) begin
            ocol_nxt = ocol_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
      rph_r  <= '0;
      cph_r  <= '0;
      orow_r <= '0;
      ocol_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      rph_r  <= rph_nxt;
      cph_r  <= cph_nxt;
      orow_r <= orow_nxt;
      ocol_r <= ocol_nxt;
    end
  end

  `MP_ASSERT(a_col_in_frame, clk, rst_n, WW'(col_r) < w_eff)
  `MP_ASSERT(a_row_in_frame, clk, rst_n, HW'(row_r) < h_eff)
  `MP_ASSERT(a_slot_in_kernel, clk, rst_n, KW'(slot_r) < k_eff)
  `MP_ASSERT_IMPL(a_close_has_phase, clk, rst_n, close, (rph_r == '0) && col_in)

endmodule

[rtl/mp2a_scan.sv]
`include "assert_macros.svh"

module mp2a_scan import mp2a_pkg::*; #(
  parameter int K_MAX     = K_MAX_DEF,
  parameter int W_MAX     = W_MAX_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int KW = $clog2(K_MAX + 1),
  localparam int SW = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  localparam int CW = $clog2(W_MAX),
  localparam int AW = $clog2(K_MAX * W_MAX)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KW-1:0]        k_eff,
  input  logic                 start,
  input  logic [SW-1:0]        base_slot,
  input  logic [CW-1:0]        base_col,
  input  win_t                 win,
  output logic                 in_ready,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [DATA_BITS-1:0] rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] pooled_value,
  output logic [COORD_W-1:0]   out_row,
  output logic [COORD_W-1:0]   out_col,
  output logic [COORD_W-1:0]   max_row,
  output logic [COORD_W-1:0]   max_col
);

  scan_state_t state_r, state_nxt;

  logic [SW-1:0]        bi_r, bi_nxt, bj_r, bj_nxt, slot_r, slot_nxt;
  logic [SW-1:0]        base_slot_r, base_slot_nxt;
  logic [CW-1:0]        base_col_r, base_col_nxt;
  win_t                 win_r, win_nxt;
  logic                 cmp_vld_r;
  logic [SW-1:0]        cmp_bi_r, cmp_bj_r;
  logic [DATA_BITS-1:0] best_r, best_nxt;
  logic [SW-1:0]        best_bi_r, best_bi_nxt, best_bj_r, best_bj_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [DATA_BITS-1:0] out_value_r;
  logic [COORD_W-1:0]   out_row_r, out_col_r, out_mrow_r, out_mcol_r;

  logic bi_last, bj_last, slot_wrap, out_free, load_out, first;

  assign bi_last   = (KW'(bi_r) + 1'b1) == k_eff;
  assign bj_last   = (KW'(bj_r) + 1'b1) == k_eff;
  assign slot_wrap = (KW'(slot_r) + 1'b1) == k_eff;
  assign out_free  = !out_vld_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (bi_last && bj_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  rd_en    = 1'b1;
      ST_DRAIN: ;
      ST_HOLD:  load_out = out_free;
    endcase
  end

  // Column-major walk over the window: rows inside, columns outside.
  always_comb begin
    bi_nxt        = bi_r;
    bj_nxt        = bj_r;
    slot_nxt      = slot_r;
    base_slot_nxt = base_slot_r;
    base_col_nxt  = base_col_r;
    win_nxt       = win_r;
    if (state_r == ST_IDLE && start) begin
      bi_nxt        = '0;
      bj_nxt        = '0;
      slot_nxt      = base_slot;
      base_slot_nxt = base_slot;
      base_col_nxt  = base_col;
      win_nxt       = win;
    end else if (state_r == ST_SCAN) begin
      if (bi_last) begin
        bi_nxt   = '0;
        bj_nxt   = bj_r + 1'b1;
        slot_nxt = base_slot_r;
      end else begin
        bi_nxt   = bi_r + 1'b1;
        slot_nxt = slot_wrap ? '0 : slot_r + 1'b1;
      end
    end
  end

  assign rd_addr = AW'(slot_r) * AW'(W_MAX) + AW'(base_col_r + bj_r);

  // Shared compare unit: read data arrives in the cycle after its address.
  assign first = (cmp_bi_r == '0) && (cmp_bj_r == '0);

  always_comb begin
    best_nxt    = best_r;
    best_bi_nxt = best_bi_r;
    best_bj_nxt = best_bj_r;
    if (cmp_vld_r && (first || ($signed(rd_data) > $signed(best_r)))) begin
      best_nxt    = rd_data;
      best_bi_nxt = cmp_bi_r;
      best_bj_nxt = cmp_bj_r;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_en;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bi_r        <= bi_nxt;
    bj_r        <= bj_nxt;
    slot_r      <= slot_nxt;
    base_slot_r <= base_slot_nxt;
    base_col_r  <= base_col_nxt;
    win_r       <= win_nxt;
    cmp_bi_r    <= bi_r;
    cmp_bj_r    <= bj_r;
    best_r      <= best_nxt;
    best_bi_r   <= best_bi_nxt;
    best_bj_r   <= best_bj_nxt;
    if (load_out) begin
      out_value_r <= best_r;
      out_row_r   <= win_r.out_row;
      out_col_r   <= win_r.out_col;
      out_mrow_r  <= win_r.row0 + COORD_W'(best_bi_r);
      out_mcol_r  <= win_r.col0 + COORD_W'(best_bj_r);
    end
  end

  assign out_valid    = out_vld_r;
  assign pooled_value = out_value_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign max_row      = out_mrow_r;
  assign max_col      = out_mcol_r;

  `MP_ASSERT_IMPL(a_scan_idx, clk, rst_n, state_r == ST_SCAN, (KW'(bi_r) < k_eff) && (KW'(bj_r) < k_eff))
  `MP_ASSERT_IMPL(a_cmp_after_issue, clk, rst_n, cmp_vld_r, $past(state_r) == ST_SCAN)
  `MP_ASSERT_IMPL(a_load_from_hold, clk, rst_n, $rose(out_vld_r), $past(state_r) == ST_HOLD)
  `MP_ASSERT_NEXT(a_hold_leaves, clk, rst_n, (state_r == ST_HOLD) && out_free, (state_r == ST_IDLE) && out_vld_r)

endmodule

[rtl/max_pool_2d_argmax_unit.sv]
// A sample that closes a window yields its word after the scan: the line store is read for every
// sample of the window in turn, the last compare finishes, and the output register is loaded.
// A sample that closes no window leaves input ready high; one that closes a window holds input
// ready low until its word is loaded, longer while the previous word waits for out_tready.
// Reset (rst_n low, synchronous) clears the position counters, the sequencer and the output
// valid flag, and sets kernel 2, stride 2, width 256, height 256.
module max_pool_2d_argmax_unit import mp2a_pkg::*; #(
  parameter int K_MAX     = K_MAX_DEF,
  parameter int W_MAX     = W_MAX_DEF,
  parameter int H_MAX     = H_MAX_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int IN_TDATA_W  = ((DATA_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_BITS + 4 * COORD_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pooled_value, out_row, out_col, max_row, max_col
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int KW = $clog2(K_MAX + 1);
  localparam int SW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(W_MAX);
  localparam int WW = $clog2(W_MAX + 1);
  localparam int HW = $clog2(H_MAX + 1);
  localparam int AW = $clog2(K_MAX * W_MAX);

  logic [KSIZE_W-1:0]  kernel_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [DIM_W-1:0]    width_r, height_r;

  logic [KW-1:0]       k_eff;
  logic [STRIDE_W-1:0] s_eff;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;

  logic                cfg_wr, accept, close;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                rd_en;
  logic [DATA_BITS-1:0] rd_data, pooled_value;
  logic [SW-1:0]       base_slot;
  logic [CW-1:0]       base_col;
  win_t                win;
  logic [COORD_W-1:0]  out_row, out_col, max_row, max_col;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KERNEL_RST;
      stride_r <= STRIDE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_KERNEL: kernel_r <= cfg_data[KSIZE_W-1:0];
        REG_STRIDE: stride_r <= cfg_data[STRIDE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // Out-of-range settings are pulled into their legal range.
  always_comb begin
    if (kernel_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(kernel_r) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(kernel_r);
    end
    s_eff = (stride_r == '0) ? STRIDE_W'(1) : stride_r;
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_r) > W_MAX) begin
      w_eff = WW'(W_MAX);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(height_r) > H_MAX) begin
      h_eff = HW'(H_MAX);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  mp2a_pos #(
    .K_MAX (K_MAX),
    .W_MAX (W_MAX),
    .H_MAX (H_MAX)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr),
    .step      (accept),
    .k_eff     (k_eff),
    .s_eff     (s_eff),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .wr_addr   (wr_addr),
    .close     (close),
    .base_slot (base_slot),
    .base_col  (base_col),
    .win       (win)
  );

  mp2a_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (K_MAX * W_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_addr),
    .wdata (in_tdata[DATA_BITS-1:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mp2a_scan #(
    .K_MAX     (K_MAX),
    .W_MAX     (W_MAX),
    .DATA_BITS (DATA_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .k_eff        (k_eff),
    .start        (accept && close),
    .base_slot    (base_slot),
    .base_col     (base_col),
    .win          (win),
    .in_ready     (in_tready),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pooled_value (pooled_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .max_row      (max_row),
    .max_col      (max_col)
  );

  assign out_tdata = OUT_TDATA_W'({max_col, max_row, out_col, out_row, pooled_value});

endmodule
